// ===== src/pei_pkg.sv =====
// Shared types and constants for the particle Euler integrator.
`default_nettype none
package pei_pkg;

  typedef struct packed {
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic signed [31:0] home_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pull_accel;
    logic [30:0]        age_now;
    logic [30:0]        lifetime;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [30:0]        new_age;
    logic               still_alive;
  } out_req_t;

  // register indexes
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_EXT_X     = 2'd1;
  localparam logic [1:0] REG_EXT_Y     = 2'd2;
  localparam logic [1:0] REG_EXT_Z     = 2'd3;

  localparam int unsigned TS_W   = 20;
  localparam int unsigned SQ_W   = 32;  // root bits (sum < 2^64)
  localparam int unsigned QT_W   = 47;  // quotient bits (mag<<16 / len)
  localparam logic [30:0] AGE_MAX = 31'h7FFF_FFFF;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (x > hi) sat32 = 32'sh7FFF_FFFF;
    else if (x < lo) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/pei_unit_vec.sv =====
// Pipelined unit vector: normalize, square, root, then divide, one bit per stage.
`default_nettype none
module pei_unit_vec #(
  parameter int unsigned TAG_W = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    in_vld,
  input  wire logic signed [32:0]      in_d [3],
  input  wire logic [TAG_W-1:0]        in_tag,
  output logic                         out_vld,
  output logic signed [47:0]           out_u [3],
  output logic [TAG_W-1:0]             out_tag
);

  localparam int unsigned NSQ = pei_pkg::SQ_W;
  localparam int unsigned NDV = pei_pkg::QT_W;

  // ---- stage A: magnitudes and their OR
  logic          a_v_r;
  logic [32:0]   a_mag_r [3];
  logic [2:0]    a_neg_r;
  logic [32:0]   a_max_r;
  logic [TAG_W-1:0] a_tag_r;

  logic [32:0] mg_nxt [3];
  logic [32:0] mx_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++)
      mg_nxt[i] = in_d[i][32] ? 33'(-in_d[i]) : 33'(in_d[i]);
    mx_nxt = mg_nxt[0] | mg_nxt[1] | mg_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_vld;
    if (adv) begin
      a_mag_r <= mg_nxt;
      a_max_r <= mx_nxt;
      for (int i = 0; i < 3; i++) a_neg_r[i] <= in_d[i][32];
      a_tag_r <= in_tag;
    end
  end

  // ---- stage B: shift so the largest sits in [2^30, 2^31)
  // leading one of OR equals leading one of the max
  logic [5:0] lz;
  always_comb begin
    lz = 6'd0;
    for (int b = 0; b < 33; b++)
      if (a_max_r[b]) lz = 6'(b);
  end

  logic        b_v_r;
  logic [30:0] b_m_r [3];
  logic [2:0]  b_neg_r;
  logic        b_zero_r;
  logic [TAG_W-1:0] b_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (lz >= 6'd30) b_m_r[i] <= 31'(a_mag_r[i] >> (lz - 6'd30));
        else b_m_r[i] <= 31'(a_mag_r[i] << (6'd30 - lz));
      end
      b_neg_r  <= a_neg_r;
      b_zero_r <= (a_max_r == 33'd0);
      b_tag_r  <= a_tag_r;
    end
  end

  // ---- stage C: squares (one 31x31 multiply each)
  logic        c_v_r;
  logic [61:0] c_sq_r [3];
  logic [30:0] c_m_r [3];
  logic [2:0]  c_neg_r;
  logic        c_zero_r;
  logic [TAG_W-1:0] c_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) c_sq_r[i] <= b_m_r[i] * b_m_r[i];
      c_m_r    <= b_m_r;
      c_neg_r  <= b_neg_r;
      c_zero_r <= b_zero_r;
      c_tag_r  <= b_tag_r;
    end
  end

  // ---- root pipeline, one result bit per stage
  logic            s_v_r   [NSQ+1];
  logic [63:0]     s_rem_r [NSQ+1];
  logic [SQ_W_L-1:0] s_root_r[NSQ+1];
  logic [30:0]     s_m_r   [NSQ+1][3];
  logic [2:0]      s_neg_r [NSQ+1];
  logic            s_zero_r[NSQ+1];
  logic [TAG_W-1:0] s_tag_r[NSQ+1];

  localparam int unsigned SQ_W_L = pei_pkg::SQ_W;

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r[0] <= 1'b0;
    else if (adv) s_v_r[0] <= c_v_r;
    if (adv) begin
      s_rem_r[0]  <= 64'(c_sq_r[0]) + 64'(c_sq_r[1]) + 64'(c_sq_r[2]);
      s_root_r[0] <= '0;
      s_m_r[0]    <= c_m_r;
      s_neg_r[0]  <= c_neg_r;
      s_zero_r[0] <= c_zero_r;
      s_tag_r[0]  <= c_tag_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam int unsigned BP = NSQ - 1 - k;
    logic [63:0] trial;
    logic [SQ_W_L-1:0] cand;
    always_comb begin
      cand  = s_root_r[k] | (SQ_W_L'(1) << BP);
      trial = 64'(cand) * 64'(cand);
    end
    // compare candidate square against the sum: rem keeps the original sum
    always_ff @(posedge clk) begin
      if (!rst_n) s_v_r[k+1] <= 1'b0;
      else if (adv) s_v_r[k+1] <= s_v_r[k];
      if (adv) begin
        s_rem_r[k+1]  <= s_rem_r[k];
        s_root_r[k+1] <= (trial <= s_rem_r[k]) ? cand : s_root_r[k];
        s_m_r[k+1]    <= s_m_r[k];
        s_neg_r[k+1]  <= s_neg_r[k];
        s_zero_r[k+1] <= s_zero_r[k];
        s_tag_r[k+1]  <= s_tag_r[k];
      end
    end
  end

  // ---- divide pipeline: three restoring dividers, one quotient bit per stage
  logic            q_v_r   [NDV+1];
  logic [47:0]     q_rem_r [NDV+1][3];
  logic [pei_pkg::QT_W-1:0] q_q_r [NDV+1][3];
  logic [46:0]     q_num_r [NDV+1][3];
  logic [SQ_W_L-1:0] q_den_r [NDV+1];
  logic [2:0]      q_neg_r [NDV+1];
  logic            q_zero_r[NDV+1];
  logic [TAG_W-1:0] q_tag_r[NDV+1];

  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r[0] <= 1'b0;
    else if (adv) q_v_r[0] <= s_v_r[NSQ];
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q_rem_r[0][i] <= '0;
        q_q_r[0][i]   <= '0;
        q_num_r[0][i] <= {s_m_r[NSQ][i], 16'd0};
      end
      q_den_r[0]  <= s_root_r[NSQ];
      q_neg_r[0]  <= s_neg_r[NSQ];
      q_zero_r[0] <= s_zero_r[NSQ] || (s_root_r[NSQ] == '0);
      q_tag_r[0]  <= s_tag_r[NSQ];
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [47:0] sh [3];
    always_comb begin
      for (int i = 0; i < 3; i++)
        sh[i] = {q_rem_r[k][i][46:0], q_num_r[k][i][46]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) q_v_r[k+1] <= 1'b0;
      else if (adv) q_v_r[k+1] <= q_v_r[k];
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          q_num_r[k+1][i] <= {q_num_r[k][i][45:0], 1'b0};
          if (sh[i] >= 48'(q_den_r[k])) begin
            q_rem_r[k+1][i] <= sh[i] - 48'(q_den_r[k]);
            q_q_r[k+1][i]   <= {q_q_r[k][i][pei_pkg::QT_W-2:0], 1'b1};
          end else begin
            q_rem_r[k+1][i] <= sh[i];
            q_q_r[k+1][i]   <= {q_q_r[k][i][pei_pkg::QT_W-2:0], 1'b0};
          end
        end
        q_den_r[k+1]  <= q_den_r[k];
        q_neg_r[k+1]  <= q_neg_r[k];
        q_zero_r[k+1] <= q_zero_r[k];
        q_tag_r[k+1]  <= q_tag_r[k];
      end
    end
  end

  // sign restore
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (q_zero_r[NDV]) out_u[i] = '0;
      else if (q_neg_r[NDV][i]) out_u[i] = -$signed({1'b0, q_q_r[NDV][i]});
      else out_u[i] = $signed({1'b0, q_q_r[NDV][i]});
    end
  end
  assign out_vld = q_v_r[NDV];
  assign out_tag = q_tag_r[NDV];

endmodule
`default_nettype wire

// ===== src/particle_euler_integrator.sv =====
// Top level of the particle Euler integrator: config, pipeline, output register.
//
//  channel | ports                          | handshake
//  input   | in_valid, in_stall, in_data    | valid && !stall
//  output  | out_valid, out_stall, out_data | valid && !stall
//  config  | cfg_we, cfg_index, cfg_wdata   | write when cfg_we
//
// One request enters per cycle while in_stall is low; out_valid rises after the
// request passes 3 normalize/square stages, the bit-per-stage square root (1 + 32
// stages), the divider (1 + 47 stages), 4 update stages and the output register.
// Reset clears all valid bits and loads register defaults.
// A held result under out_stall freezes the whole pipeline; in_stall follows
// out_stall in the same cycle, so no request is lost or repeated.
`default_nettype none
module particle_euler_integrator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pei_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pei_pkg::out_req_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  // configuration registers
  logic [19:0]        ts_r;
  logic signed [31:0] ext_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= 20'd1092;
      for (int i = 0; i < 3; i++) ext_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pei_pkg::REG_TIME_STEP: ts_r <= cfg_wdata[19:0];
        pei_pkg::REG_EXT_X:     ext_r[0] <= cfg_wdata;
        pei_pkg::REG_EXT_Y:     ext_r[1] <= cfg_wdata;
        pei_pkg::REG_EXT_Z:     ext_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances when output slot frees
  logic adv;
  logic out_full_r;
  assign adv = !out_full_r || !out_stall;
  assign in_stall = !adv;
  wire in_acc = in_valid && adv;

  // distance to home, exact in 33 bits
  logic signed [32:0] d_in [3];
  always_comb begin
    d_in[0] = 33'(in_data.home_x) - 33'(in_data.pos_x);
    d_in[1] = 33'(in_data.home_y) - 33'(in_data.pos_y);
    d_in[2] = 33'(in_data.home_z) - 33'(in_data.pos_z);
  end

  // side data travel through the unit-vector pipeline as a tag
  localparam int unsigned TAG_W = $bits(pei_pkg::in_req_t) - 96;
  logic [TAG_W-1:0] tag_in, tag_out;
  logic u_vld;
  logic signed [47:0] u [3];
  assign tag_in = {in_data.pos_x, in_data.pos_y, in_data.pos_z,
                   in_data.vel_x, in_data.vel_y, in_data.vel_z,
                   in_data.pull_accel, in_data.age_now, in_data.lifetime};

  pei_unit_vec #(.TAG_W(TAG_W)) u_uv (
    .clk, .rst_n, .adv, .in_vld(in_acc), .in_d(d_in), .in_tag(tag_in),
    .out_vld(u_vld), .out_u(u), .out_tag(tag_out)
  );

  // unpack tag
  logic signed [31:0] t_pos [3], t_vel [3], t_pull;
  logic [30:0] t_age, t_life;
  assign {t_pos[0], t_pos[1], t_pos[2], t_vel[0], t_vel[1], t_vel[2],
          t_pull, t_age, t_life} = tag_out;

  // stage 1: age, k product, ext products
  // |u| never exceeds 2^16, so 18 signed bits hold it
  logic s1_v_r;
  logic signed [52:0] k_prod_r;
  logic signed [52:0] e_prod_r [3];
  logic signed [17:0] s1_u_r [3];
  logic signed [31:0] s1_pos_r [3], s1_vel_r [3];
  logic [30:0] s1_age_r;
  logic s1_alive_r;
  logic [31:0] age_sum;
  logic [30:0] age_sat;
  always_comb begin
    age_sum = 32'(t_age) + 32'(ts_r);
    age_sat = age_sum[31] ? pei_pkg::AGE_MAX : age_sum[30:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= u_vld;
    if (adv) begin
      k_prod_r <= 53'(t_pull) * $signed({1'b0, ts_r});
      for (int i = 0; i < 3; i++) begin
        e_prod_r[i] <= 53'(ext_r[i]) * $signed({1'b0, ts_r});
        s1_u_r[i]   <= 18'(u[i]);
      end
      s1_pos_r <= t_pos; s1_vel_r <= t_vel;
      s1_age_r <= age_sat; s1_alive_r <= (age_sat <= t_life);
    end
  end

  // stage 2: u * k
  logic s2_v_r;
  logic signed [54:0] uk_r [3];
  logic signed [36:0] e_r [3];
  logic signed [31:0] s2_pos_r [3], s2_vel_r [3];
  logic [30:0] s2_age_r;
  logic s2_alive_r;
  logic signed [36:0] kq;
  assign kq = 37'(k_prod_r >>> 16);
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        uk_r[i] <= 55'(s1_u_r[i]) * 55'(kq);
        e_r[i]  <= 37'(e_prod_r[i] >>> 16);
      end
      s2_pos_r <= s1_pos_r; s2_vel_r <= s1_vel_r;
      s2_age_r <= s1_age_r; s2_alive_r <= s1_alive_r;
    end
  end

  // stage 3: new velocity
  logic s3_v_r;
  logic signed [31:0] nv_r [3], s3_pos_r [3], s3_vel_r [3];
  logic [30:0] s3_age_r;
  logic s3_alive_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++)
        nv_r[i] <= pei_pkg::sat32(68'(s2_vel_r[i]) + 68'(uk_r[i] >>> 16) + 68'(e_r[i]));
      s3_pos_r <= s2_pos_r; s3_vel_r <= s2_vel_r;
      s3_age_r <= s2_age_r; s3_alive_r <= s2_alive_r;
    end
  end

  // stage 4: v * dt
  logic s4_v_r;
  logic signed [52:0] pv_r [3];
  logic signed [31:0] s4_nv_r [3], s4_pos_r [3], s4_vel_r [3];
  logic [30:0] s4_age_r;
  logic s4_alive_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) pv_r[i] <= 53'(nv_r[i]) * $signed({1'b0, ts_r});
      s4_nv_r <= nv_r; s4_pos_r <= s3_pos_r; s4_vel_r <= s3_vel_r;
      s4_age_r <= s3_age_r; s4_alive_r <= s3_alive_r;
    end
  end

  // output register
  pei_pkg::out_req_t o_nxt;
  logic signed [31:0] np [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      np[i] = s4_alive_r ? pei_pkg::sat32(68'(s4_pos_r[i]) + 68'(pv_r[i] >>> 16))
                         : s4_pos_r[i];
    o_nxt.new_pos_x = np[0];
    o_nxt.new_pos_y = np[1];
    o_nxt.new_pos_z = np[2];
    o_nxt.new_vel_x = s4_alive_r ? s4_nv_r[0] : s4_vel_r[0];
    o_nxt.new_vel_y = s4_alive_r ? s4_nv_r[1] : s4_vel_r[1];
    o_nxt.new_vel_z = s4_alive_r ? s4_nv_r[2] : s4_vel_r[2];
    o_nxt.new_age = s4_age_r;
    o_nxt.still_alive = s4_alive_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (adv) out_full_r <= s4_v_r;
    if (adv) out_data <= o_nxt;
  end
  assign out_valid = out_full_r;

  // assertions
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("stalled with empty output");
  // a dead particle has an age above its lifetime, so never zero
  a_dead_age: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.still_alive |-> out_data.new_age != 31'd0)
    else $error("dead particle with zero age");

endmodule
`default_nettype wire

// ===== test/particle_euler_integrator_test.sv =====
// Self-checking testbench for the particle Euler integrator: scoreboard class plus driver tasks.
`default_nettype none

// Keeps the register copy, predicts each particle step and checks the results in order.
class motion_scoreboard;
  localparam longint unsigned AGE_TOP = 64'h7FFF_FFFF;

  pei_pkg::out_req_t expected_steps[$];
  longint unsigned   tick;
  longint            accel[3];
  int                mismatches;
  int                steps_checked;
  int                deaths_seen;

  function new();
    tick = 1092;
    accel[0] = 0;
    accel[1] = 0;
    accel[2] = 0;
    mismatches = 0;
    steps_checked = 0;
    deaths_seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      pei_pkg::REG_TIME_STEP: tick = val[19:0];
      pei_pkg::REG_EXT_X:     accel[0] = longint'(signed'(val));
      pei_pkg::REG_EXT_Y:     accel[1] = longint'(signed'(val));
      pei_pkg::REG_EXT_Z:     accel[2] = longint'(signed'(val));
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_steps.size();
  endfunction

  // bit-pair integer square root, floor
  function longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // direction toward home, scaled to Q16.16 unit length
  function void toward_home(longint d[3], output longint u[3]);
    longint unsigned mag[3];
    longint unsigned top;
    longint unsigned sum;
    longint unsigned len;
    longint          q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      if (mag[i] > top) top = mag[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (top == 0) return;
    while (top >= 64'h8000_0000) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (top < 64'h4000_0000) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = root_floor(sum);
    if (len == 0) return;
    for (int i = 0; i < 3; i++) begin
      q = longint'((mag[i] << 16) / len);
      u[i] = (d[i] < 0) ? -q : q;
    end
  endfunction

  // one accepted request: work out the updated particle
  function void note_input(pei_pkg::in_req_t r);
    pei_pkg::out_req_t e;
    longint home[3], pos[3], vel[3], d[3], u[3];
    longint unsigned age;
    longint dt;
    longint k;
    longint v;
    bit alive;
    dt = longint'(tick);
    age = longint'({33'd0, r.age_now}) + tick;
    if (age > AGE_TOP) age = AGE_TOP;
    alive = age <= longint'({33'd0, r.lifetime});
    home[0] = r.home_x; home[1] = r.home_y; home[2] = r.home_z;
    pos[0] = r.pos_x;   pos[1] = r.pos_y;   pos[2] = r.pos_z;
    vel[0] = r.vel_x;   vel[1] = r.vel_y;   vel[2] = r.vel_z;
    for (int i = 0; i < 3; i++) d[i] = home[i] - pos[i];
    if (alive) begin
      k = (longint'(r.pull_accel) * dt) >>> 16;
      toward_home(d, u);
      for (int i = 0; i < 3; i++) begin
        v = vel[i] + ((u[i] * k) >>> 16) + ((accel[i] * dt) >>> 16);
        vel[i] = clip32(v);
        pos[i] = clip32(pos[i] + ((vel[i] * dt) >>> 16));
      end
    end else begin
      deaths_seen++;
    end
    e.new_pos_x = pos[0][31:0]; e.new_pos_y = pos[1][31:0]; e.new_pos_z = pos[2][31:0];
    e.new_vel_x = vel[0][31:0]; e.new_vel_y = vel[1][31:0]; e.new_vel_z = vel[2][31:0];
    e.new_age = age[30:0];
    e.still_alive = alive;
    expected_steps.insert(expected_steps.size(), e);
  endfunction

  task report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d (0x%0h), expected %0d (0x%0h) at %0t",
             what, got, got, want, want, $realtime);
  endtask

  task check_result(pei_pkg::out_req_t g);
    pei_pkg::out_req_t w;
    if (expected_steps.size() == 0) begin
      report_mismatch("unexpected result", g.new_age, 0);
      return;
    end
    w = expected_steps.pop_front();
    steps_checked++;
    if (g.new_pos_x !== w.new_pos_x) report_mismatch("new_pos_x", g.new_pos_x, w.new_pos_x);
    if (g.new_pos_y !== w.new_pos_y) report_mismatch("new_pos_y", g.new_pos_y, w.new_pos_y);
    if (g.new_pos_z !== w.new_pos_z) report_mismatch("new_pos_z", g.new_pos_z, w.new_pos_z);
    if (g.new_vel_x !== w.new_vel_x) report_mismatch("new_vel_x", g.new_vel_x, w.new_vel_x);
    if (g.new_vel_y !== w.new_vel_y) report_mismatch("new_vel_y", g.new_vel_y, w.new_vel_y);
    if (g.new_vel_z !== w.new_vel_z) report_mismatch("new_vel_z", g.new_vel_z, w.new_vel_z);
    if (g.new_age !== w.new_age) report_mismatch("new_age", g.new_age, w.new_age);
    if (g.still_alive !== w.still_alive)
      report_mismatch("still_alive", g.still_alive, w.still_alive);
  endtask
endclass

module particle_euler_integrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IN_W = $bits(pei_pkg::in_req_t);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pei_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  pei_pkg::out_req_t out_data;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_wdata;

  motion_scoreboard board;
  int  cycles;
  bit  send_gaps;
  bit  recv_gaps;
  int  hold_cycles;
  int  settings_used;

  particle_euler_integrator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_input(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= recv_gaps && ($urandom_range(99) < 32);
    end
  end

  // called at a falling edge; leaves in_valid high so the next request can follow directly
  task automatic send_request(pei_pkg::in_req_t d);
    while (send_gaps && ($urandom_range(99) < 32)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // back-to-back offer used under receiver hold-off
  task automatic send_burst(int n);
    pei_pkg::in_req_t d;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      d = make_particle($urandom_range(99) < 85);
      in_valid = 1'b1;
      in_data = d;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, val);
  endtask

  // wait for every expected result, then end on a falling edge
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [31:0] ts, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] az);
    settle();
    write_reg(pei_pkg::REG_TIME_STEP, ts);
    write_reg(pei_pkg::REG_EXT_X, ax);
    write_reg(pei_pkg::REG_EXT_Y, ay);
    write_reg(pei_pkg::REG_EXT_Z, az);
    settings_used++;
  endtask

  function automatic logic [31:0] near(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // plausible particle most of the time, raw noise otherwise
  function automatic pei_pkg::in_req_t make_particle(bit sane);
    pei_pkg::in_req_t p;
    logic [30:0] base;
    if (!sane) begin
      p = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(3) == 0)
        p.age_now = 31'(32'h7FFF_FFFF - $urandom_range(1 << 20));
      return p;
    end
    p.home_x = near(1 << 24); p.home_y = near(1 << 24); p.home_z = near(1 << 24);
    p.pos_x = near(1 << 24);  p.pos_y = near(1 << 24);  p.pos_z = near(1 << 24);
    p.vel_x = near(1 << 22);  p.vel_y = near(1 << 22);  p.vel_z = near(1 << 22);
    p.pull_accel = near(1 << 21);
    if ($urandom_range(9) == 0) p.pos_y = p.home_y;
    base = 31'($urandom_range(1 << 24));
    p.age_now = base;
    p.lifetime = ($urandom_range(9) == 0) ? base : 31'(base + $urandom_range(1 << 22));
    return p;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_request(make_particle($urandom_range(99) < 80));
    in_valid = 1'b0;
  endtask

  task automatic directed_part();
    pei_pkg::in_req_t p;
    // all zero: zero distance, new age over the zero lifetime
    p = '0;
    send_request(p);
    // home equals position, nonzero values
    p = '0;
    p.home_x = 32'sd65536; p.pos_x = 32'sd65536; p.pull_accel = 32'sd655360;
    p.lifetime = 31'd100000;
    send_request(p);
    // widest distance on every axis
    p.home_x = 32'sh7FFF_FFFF; p.home_y = 32'sh8000_0000; p.home_z = 32'sh7FFF_FFFF;
    p.pos_x = 32'sh8000_0000;  p.pos_y = 32'sh7FFF_FFFF;  p.pos_z = 32'sh8000_0000;
    p.pull_accel = 32'sh7FFF_FFFF;
    send_request(p);
    p.pull_accel = 32'sh8000_0000;
    send_request(p);
    // tiny distance on one axis
    p = '0;
    p.home_z = 32'sd1; p.pull_accel = 32'sh0100_0000; p.lifetime = 31'd5000;
    send_request(p);
    // velocity pinned at the limits
    p = '0;
    p.vel_x = 32'sh7FFF_FFFF; p.vel_y = 32'sh8000_0000; p.vel_z = 32'sh7FFF_FFFF;
    p.pos_x = 32'sh7FFF_FFFF; p.pos_y = 32'sh8000_0000; p.home_x = 32'sd5;
    p.pull_accel = 32'sh7FFF_FFFF; p.lifetime = 31'h7FFF_FFFF;
    send_request(p);
    // death: new age just over the lifetime
    p.age_now = 31'd1000; p.lifetime = 31'd1000;
    send_request(p);
    // new age lands exactly on the lifetime at the reset tick
    p.age_now = 31'd1000; p.lifetime = 31'd2092;
    send_request(p);
    // age overflow, with and without the longest lifetime
    p.age_now = 31'h7FFF_FFFF; p.lifetime = 31'h7FFF_FFFF;
    send_request(p);
    p.age_now = 31'h7FFF_FF00; p.lifetime = 31'h7FFF_FFFE;
    send_request(p);
    p.lifetime = 31'd0; p.age_now = 31'd0;
    send_request(p);
    for (int i = 0; i < 6; i++) send_request(make_particle(i[0]));
    in_valid = 1'b0;
  endtask

  initial begin
    board = new();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pei_pkg::REG_TIME_STEP;
    cfg_wdata = '0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_cycles = 0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset register values first
    directed_part();
    random_phase(120);

    apply_setting(32'd65536, 32'sd1000, -32'sd1000, 32'sd65536);
    directed_part();
    random_phase(200);

    // no idling on either side
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    random_phase(200);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;

    // extremes: zero tick, largest tick, rails of the acceleration
    apply_setting(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    random_phase(150);
    apply_setting(32'd655360, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    directed_part();
    random_phase(150);
    apply_setting(32'hFFFFF, 32'd0, 32'd0, 32'd0);
    random_phase(100);

    // receiver holds off while requests keep coming
    apply_setting(32'd4096, $urandom, $urandom, $urandom);
    hold_cycles = 300;
    send_burst(180);
    settle();
    random_phase(150);

    apply_setting($urandom_range(655360), near(1 << 20), near(1 << 20), near(1 << 20));
    random_phase(150);

    settle();
    $display("Covered %0d particle steps (%0d deaths) over %0d register settings,",
             board.steps_checked, board.deaths_seen, settings_used + 1);
    $display("including zero and largest ticks, rail accelerations and back-pressure.");
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
